@@ src/vbbox_pkg.sv @@
// ----------------------------------------------------------------------------
// vbbox_pkg
// Shared types and constants for the voxel brick bounding box block.
// ----------------------------------------------------------------------------
package vbbox_pkg;

	localparam int unsigned COORD_W = 5;   // one axis coordinate, 0..31
	localparam int unsigned BOUND_W = 6;   // half-open bound, 0..32
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned INDEX_W = 9;

	localparam logic [BOUND_W-1:0] AXIS_SIZE = 6'd32;

	// per-word extent of the set bits
	typedef struct packed {
		logic               hit;
		logic [COORD_W-1:0] xmin;
		logic [COORD_W-1:0] xmax;
		logic [COORD_W-1:0] ymin;
		logic [COORD_W-1:0] ymax;
		logic [COORD_W-1:0] z;
	} word_ext_t;

	// one result item, field order as on the output bus (lowest first)
	typedef struct packed {
		logic [BOUND_W-1:0] z_hi;
		logic [BOUND_W-1:0] y_hi;
		logic [BOUND_W-1:0] x_hi;
		logic [BOUND_W-1:0] z_lo;
		logic [BOUND_W-1:0] y_lo;
		logic [BOUND_W-1:0] x_lo;
		logic               found;
	} box_t;

endpackage

@@ src/vbbox_word_decode.sv @@
// ----------------------------------------------------------------------------
// vbbox_word_decode
// Priority encoders that reduce one 64-bit occupancy word to its x, y and z
// extent.
// ----------------------------------------------------------------------------
module vbbox_word_decode import vbbox_pkg::*; (
	input  logic [WORD_W-1:0]  bits_word,
	input  logic [INDEX_W-1:0] word_index,
	output word_ext_t          ext
);

	function automatic logic [COORD_W-1:0] low_pos(input logic [31:0] v);
		logic [COORD_W-1:0] p;
		p = 5'd31;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) begin
				p = COORD_W'(i);
			end
		end
		return p;
	endfunction

	function automatic logic [COORD_W-1:0] high_pos(input logic [31:0] v);
		logic [COORD_W-1:0] p;
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				p = COORD_W'(i);
			end
		end
		return p;
	endfunction

	logic [31:0] row_lo;
	logic [31:0] row_hi;
	logic [31:0] row_any;
	logic [COORD_W-1:0] ybase;

	assign row_lo  = bits_word[31:0];
	assign row_hi  = bits_word[63:32];
	assign row_any = row_lo | row_hi;
	// low half is the even row, high half the odd row
	assign ybase   = {word_index[3:0], 1'b0};

	always_comb begin
		ext.hit  = |row_any;
		ext.xmin = low_pos(row_any);
		ext.xmax = high_pos(row_any);
		ext.ymin = (|row_lo) ? ybase : {word_index[3:0], 1'b1};
		ext.ymax = (|row_hi) ? {word_index[3:0], 1'b1} : ybase;
		ext.z    = word_index[8:4];
	end

endmodule

@@ src/vbbox_accum.sv @@
// ----------------------------------------------------------------------------
// vbbox_accum
// Running box registers and the result register.
// ----------------------------------------------------------------------------
module vbbox_accum import vbbox_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic      brick_full,
	input  logic      last_word,
	input  word_ext_t ext,
	input  logic      res_ready,
	output logic      slot_free,
	output logic      res_valid,
	output box_t      res
);

	logic               seen_q;
	logic [COORD_W-1:0] min_x_q, min_y_q, min_z_q;
	logic [COORD_W-1:0] max_x_q, max_y_q, max_z_q;
	logic               out_valid_q;
	box_t               res_q;

	logic               seen_n;
	logic [COORD_W-1:0] min_x_n, min_y_n, min_z_n;
	logic [COORD_W-1:0] max_x_n, max_y_n, max_z_n;
	logic               ends;
	box_t               box_n;

	assign ends      = brick_full | last_word;
	assign slot_free = !out_valid_q || res_ready;

	// fold the word into the running box
	always_comb begin
		seen_n  = seen_q;
		min_x_n = min_x_q;
		min_y_n = min_y_q;
		min_z_n = min_z_q;
		max_x_n = max_x_q;
		max_y_n = max_y_q;
		max_z_n = max_z_q;
		if (ext.hit) begin
			seen_n  = 1'b1;
			min_x_n = (!seen_q || ext.xmin < min_x_q) ? ext.xmin : min_x_q;
			min_y_n = (!seen_q || ext.ymin < min_y_q) ? ext.ymin : min_y_q;
			min_z_n = (!seen_q || ext.z    < min_z_q) ? ext.z    : min_z_q;
			max_x_n = (!seen_q || ext.xmax > max_x_q) ? ext.xmax : max_x_q;
			max_y_n = (!seen_q || ext.ymax > max_y_q) ? ext.ymax : max_y_q;
			max_z_n = (!seen_q || ext.z    > max_z_q) ? ext.z    : max_z_q;
		end
	end

	always_comb begin
		box_n = '0;
		if (brick_full) begin
			box_n.found = 1'b1;
			box_n.x_hi  = AXIS_SIZE;
			box_n.y_hi  = AXIS_SIZE;
			box_n.z_hi  = AXIS_SIZE;
		end else if (seen_n) begin
			box_n.found = 1'b1;
			box_n.x_lo  = {1'b0, min_x_n};
			box_n.y_lo  = {1'b0, min_y_n};
			box_n.z_lo  = {1'b0, min_z_n};
			box_n.x_hi  = {1'b0, max_x_n} + 6'd1;
			box_n.y_hi  = {1'b0, max_y_n} + 6'd1;
			box_n.z_hi  = {1'b0, max_z_n} + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (step) begin
			seen_q <= ends ? 1'b0 : seen_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			min_x_q <= min_x_n;
			min_y_q <= min_y_n;
			min_z_q <= min_z_n;
			max_x_q <= max_x_n;
			max_y_q <= max_y_n;
			max_z_q <= max_z_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && ends) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && ends) begin
			res_q <= box_n;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && ends |=> !seen_q)
		else $error("running box not cleared after brick end");

	a_end_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		step && ends |-> slot_free)
		else $error("brick end taken while result register busy");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (min_x_q <= max_x_q) && (min_y_q <= max_y_q) && (min_z_q <= max_z_q))
		else $error("running minimum above running maximum");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.found |-> (res_q.x_lo == '0) && (res_q.y_lo == '0)
			&& (res_q.z_lo == '0) && (res_q.x_hi == '0) && (res_q.y_hi == '0)
			&& (res_q.z_hi == '0))
		else $error("empty brick result carries nonzero bounds");

endmodule

@@ src/voxel_brick_bounding_box.sv @@
// ----------------------------------------------------------------------------
// voxel_brick_bounding_box
// Bounding box of the set voxels of a 32x32x32 occupancy brick streamed as
// 64-bit words.
//
//   bus  dir  contents
//   s_*  in   tdata: bits_word[63:0], word_index[72:64]; tuser: brick_full;
//             tlast: last_word
//   m_*  out  tdata: found (1 bit), x_lo, y_lo, z_lo, x_hi, y_hi, z_hi (6 bits each)
//
// One word per cycle while no brick end is held back; a word goes input register
// -> encoders and min/max -> running box, and a brick end's box to the result register.
// A brick end holds in the input register while the result register is full
// and not taken; other words never wait on the output side.
// arst_n clears valids and the running box; bounds registers need no reset.
// ----------------------------------------------------------------------------
module voxel_brick_bounding_box import vbbox_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // bits_word[63:0], word_index[72:64], zero fill
	input  logic        s_tuser,   // brick_full
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // found, x_lo, y_lo, z_lo, x_hi, y_hi, z_hi, zero fill
);

	logic               valid_s1;
	logic [WORD_W-1:0]  bits_s1;
	logic [INDEX_W-1:0] index_s1;
	logic               full_s1;
	logic               last_s1;

	logic      step;
	logic      slot_free;
	word_ext_t ext;
	box_t      res;

	// advance unless a brick end would overwrite a waiting result
	assign step     = valid_s1 && (!(full_s1 || last_s1) || slot_free);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			bits_s1  <= s_tdata[63:0];
			index_s1 <= s_tdata[72:64];
			full_s1  <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	vbbox_word_decode u_decode (
		.bits_word (bits_s1),
		.word_index(index_s1),
		.ext       (ext)
	);

	vbbox_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.brick_full(full_s1),
		.last_word (last_s1),
		.ext       (ext),
		.res_ready (m_tready),
		.slot_free (slot_free),
		.res_valid (m_tvalid),
		.res       (res)
	);

	assign m_tdata = {3'b000, res};

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for voxel_brick_bounding_box. Bricks of occupancy words
// are queued up front and streamed in by a clocked driver. Each accepted item
// is folded into a local bounding-box predictor. A clocked monitor checks
// every result against the oldest predicted box. Both sides idle in random
// bursts, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top import vbbox_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int CALM_ITEMS   = 200;   // no idling while this few items are left
	localparam int SQUEEZE_AT   = 40;    // results seen before the long hold-off
	localparam int SQUEEZE_LEN  = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [BOUND_W-1:0] NONE_SEEN = 6'd63;

	typedef struct {
		logic [WORD_W-1:0]  bits;
		logic [INDEX_W-1:0] idx;
		logic               full;
		logic               last;
	} brick_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	brick_word_t words_to_send[$];
	box_t        boxes_due[$];

	// running box of the brick in progress
	logic [BOUND_W-1:0] min_x, min_y, min_z;
	logic [BOUND_W-1:0] max_x, max_y, max_z;

	int cycles = 0;
	int errors = 0;
	int mismatches = 0;
	int results_seen = 0;
	int send_gap = 0;
	int hold_left = 0;
	bit squeezed = 0;

	voxel_brick_bounding_box uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_box();
		min_x = AXIS_SIZE;
		min_y = AXIS_SIZE;
		min_z = AXIS_SIZE;
		max_x = NONE_SEEN;
		max_y = NONE_SEEN;
		max_z = NONE_SEEN;
	endfunction

	// fold one accepted word into the running box; queue a box on a brick end
	function automatic void fold_brick_word(input brick_word_t w);
		logic [31:0]        lo_half, hi_half, both;
		logic [BOUND_W-1:0] xlo, xhi, ylo, yhi, zc, ybase;
		box_t               bx;
		lo_half = w.bits[31:0];
		hi_half = w.bits[63:32];
		both = lo_half | hi_half;
		xlo = '0;
		xhi = '0;
		if (w.full) begin
			bx.found = 1'b1;
			bx.x_lo = '0;
			bx.y_lo = '0;
			bx.z_lo = '0;
			bx.x_hi = AXIS_SIZE;
			bx.y_hi = AXIS_SIZE;
			bx.z_hi = AXIS_SIZE;
			boxes_due.push_back(bx);
			clear_box();
			return;
		end
		if (both != '0) begin
			for (int i = 31; i >= 0; i--)
				if (both[i]) xlo = BOUND_W'(i);
			for (int i = 0; i < 32; i++)
				if (both[i]) xhi = BOUND_W'(i);
			zc = BOUND_W'(w.idx[8:4]);
			ybase = BOUND_W'({w.idx[3:0], 1'b0});
			ylo = (lo_half != '0) ? ybase : ybase + 6'd1;
			yhi = (hi_half != '0) ? ybase + 6'd1 : ybase;
			if (xlo < min_x) min_x = xlo;
			if (ylo < min_y) min_y = ylo;
			if (zc < min_z) min_z = zc;
			if (max_x == NONE_SEEN || xhi > max_x) max_x = xhi;
			if (max_y == NONE_SEEN || yhi > max_y) max_y = yhi;
			if (max_z == NONE_SEEN || zc > max_z) max_z = zc;
		end
		if (!w.last) return;
		if (max_x == NONE_SEEN) begin
			bx = '0;
		end else begin
			bx.found = 1'b1;
			bx.x_lo = min_x;
			bx.y_lo = min_y;
			bx.z_lo = min_z;
			bx.x_hi = max_x + 6'd1;
			bx.y_hi = max_y + 6'd1;
			bx.z_hi = max_z + 6'd1;
		end
		boxes_due.push_back(bx);
		clear_box();
	endfunction

	function automatic void queue_word(input logic [WORD_W-1:0] bits,
			input int idx, input bit full, input bit last);
		brick_word_t w;
		w.bits = bits;
		w.idx = INDEX_W'(idx);
		w.full = full;
		w.last = last;
		words_to_send.push_back(w);
	endfunction

	function automatic logic [WORD_W-1:0] random_occupancy();
		logic [WORD_W-1:0] w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: w = '0;
			4, 5: w = 64'd1 << $urandom_range(0, 63);
			6: w = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
			7, 8: w = {$urandom, $urandom};
			default: w = '1;
		endcase
		return w;
	endfunction

	// short brick of mostly consecutive words, now and then cut short by a
	// full item, with a stray item in front of it at times
	function automatic void queue_random_brick();
		int n, start, idx;
		if ($urandom_range(0, 9) == 0)
			queue_word(random_occupancy(), $urandom_range(0, 511),
				$urandom_range(0, 3) == 0, $urandom_range(0, 1) == 1);
		n = $urandom_range(1, 24);
		start = $urandom_range(0, 511);
		for (int k = 0; k < n; k++) begin
			idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : (start + k) % 512;
			if (k == n - 1 && $urandom_range(0, 7) == 0)
				queue_word(random_occupancy(), idx, 1'b1, $urandom_range(0, 1) == 1);
			else
				queue_word(random_occupancy(), idx, 1'b0, k == n - 1);
		end
	endfunction

	initial begin
		clear_box();
		// empty brick, full items with and without last set
		queue_word('0, 0, 0, 1);
		queue_word('1, 511, 1, 0);
		queue_word('0, 0, 1, 1);
		// single corner voxels
		queue_word(64'd1, 0, 0, 1);
		queue_word(64'd1 << 63, 511, 0, 1);
		// solid word at the top slice
		queue_word('1, 9'h1F0, 0, 1);
		// partial brick dropped by a full item, then an empty brick
		queue_word(64'h10, 5, 0, 0);
		queue_word(64'hFFFF_0000_0000_0000, 300, 0, 0);
		queue_word(64'h5, 301, 1, 0);
		queue_word('0, 7, 0, 1);
		// repeated index merges, missing words count as empty
		queue_word(64'h0000_0000_8000_0000, 17, 0, 0);
		queue_word(64'h0000_0001_0000_0000, 17, 0, 0);
		queue_word('0, 40, 0, 1);
		// several empty words before the end
		queue_word('0, 100, 0, 0);
		queue_word('0, 101, 0, 0);
		queue_word('0, 102, 0, 1);
		// one half only, then both halves
		queue_word(64'h0000_0400_0000_0000, 255, 0, 1);
		queue_word(64'h0000_0000_0000_0200, 256, 0, 1);
		queue_word(64'hAAAA_AAAA_5555_5555, 128, 0, 1);

		while (words_to_send.size() < 500)
			queue_random_brick();
		// one whole brick, sparse
		for (int k = 0; k < 512; k++)
			queue_word(($urandom_range(0, 15) == 0) ? 64'd1 << $urandom_range(0, 63) : '0,
				k, 0, k == 511);
		while (words_to_send.size() < 1400)
			queue_random_brick();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (words_to_send.size() != 0 || s_tvalid)
			@(posedge clk);
		while (boxes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		brick_word_t w;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				w.bits = s_tdata[63:0];
				w.idx = s_tdata[72:64];
				w.full = s_tuser;
				w.last = s_tlast;
				fold_brick_word(w);
			end
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (words_to_send.size() >= CALM_ITEMS
						&& $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(1, 19) - 1;
					s_tvalid <= 1'b0;
				end else if (words_to_send.size() != 0) begin
					w = words_to_send.pop_front();
					s_tdata <= {7'b0, w.idx, w.bits};
					s_tuser <= w.full;
					s_tlast <= w.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		box_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got = box_t'(m_tdata[$bits(box_t)-1:0]);
				if (boxes_due.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected box: found=%0d x=[%0d,%0d) y=[%0d,%0d) z=[%0d,%0d)",
							got.found, got.x_lo, got.x_hi, got.y_lo, got.y_hi,
							got.z_lo, got.z_hi);
				end else begin
					want = boxes_due.pop_front();
					if (got !== want) begin
						errors++;
						mismatches++;
						if (mismatches <= 10)
							$display({"box %0d mismatch: found %0d/%0d x_lo %0d/%0d x_hi %0d/%0d",
								" y_lo %0d/%0d y_hi %0d/%0d z_lo %0d/%0d z_hi %0d/%0d",
								" (expected/actual)"}, results_seen,
								want.found, got.found, want.x_lo, got.x_lo,
								want.x_hi, got.x_hi, want.y_lo, got.y_lo,
								want.y_hi, got.y_hi, want.z_lo, got.z_lo,
								want.z_hi, got.z_hi);
					end
				end
			end
			// one long hold-off so brick ends back up into the input
			if (!squeezed && results_seen >= SQUEEZE_AT) begin
				squeezed = 1;
				hold_left = SQUEEZE_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (words_to_send.size() >= CALM_ITEMS && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

endmodule
